/* design/rdtl_pkg.sv */
// Shared types, character codes, class codes and helpers for the text lexer.
package rdtl_pkg;

    localparam int LINE_BITS_DEF = 16;
    localparam int LINE_OUT_W    = 16;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);

    // Token classes
    localparam logic [3:0] CLS_REC_HDR   = 4'd0;
    localparam logic [3:0] CLS_REC_TYPE  = 4'd1;
    localparam logic [3:0] CLS_REC_NAME  = 4'd2;
    localparam logic [3:0] CLS_FLD_HDR   = 4'd3;
    localparam logic [3:0] CLS_FLD_NAME  = 4'd4;
    localparam logic [3:0] CLS_FLD_VALUE = 4'd5;
    localparam logic [3:0] CLS_LPAREN    = 4'd6;
    localparam logic [3:0] CLS_RPAREN    = 4'd7;
    localparam logic [3:0] CLS_LBRACE    = 4'd8;
    localparam logic [3:0] CLS_RBRACE    = 4'd9;
    localparam logic [3:0] CLS_COMMA     = 4'd10;
    localparam logic [3:0] CLS_QUOTE     = 4'd11;
    localparam logic [3:0] CLS_INVALID   = 4'd12;

    // Characters
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // One classification job: held character against its lookahead
    typedef struct packed {
        logic [7:0]            tok;
        logic [7:0]            look;
        logic [LINE_OUT_W-1:0] line;
        logic                  last;
    } rdtl_entry_t;

    typedef struct packed {
        logic        valid;
        rdtl_entry_t entry;
    } rdtl_push_t;

    function automatic logic is_word(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_DOT;
    endfunction

    function automatic logic [3:0] punct_class(input logic [7:0] c);
        logic [3:0] r;
        case (c)
            CH_LPAREN: r = CLS_LPAREN;
            CH_RPAREN: r = CLS_RPAREN;
            CH_LBRACE: r = CLS_LBRACE;
            CH_RBRACE: r = CLS_RBRACE;
            CH_COMMA:  r = CLS_COMMA;
            CH_QUOTE:  r = CLS_QUOTE;
            default:   r = CLS_INVALID;
        endcase
        return r;
    endfunction

endpackage

/* design/record_db_text_lexer_core.sv */
// Top level of the record database text lexer.
// Bytes of a text enter one per beat on the s_ channel; tab, space and CR are
// dropped, LF advances a saturating LINE_BITS-wide line counter, and every
// visible character leaves on the m_ channel with its token class, end-of-token
// mark and line, one beat behind, since the following visible character decides
// its class. A byte is taken every cycle while the job queue has room and no
// second job is pending; a final byte that both releases a held character and
// is itself visible yields two results and holds s_ready low until the front
// end has issued the second job, which waits while the job queue is full. The
// classifier retires one job per cycle into the output register while that
// register is empty or being read, so results then leave at one per cycle; a
// job passes from the job queue into the output register, where it is offered.
// A final byte that is not visible, with nothing held, gives no result.
module record_db_text_lexer_core #(
    parameter int LINE_BITS = rdtl_pkg::LINE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_token_byte,
    output logic [3:0]  m_token_class,
    output logic        m_token_end,
    output logic [15:0] m_line_number,
    output logic        m_last_result
);

    rdtl_pkg::rdtl_push_t  q_push;
    rdtl_pkg::rdtl_entry_t q_head;
    logic q_full, q_empty, q_pop;

    rdtl_front #(
        .LINE_BITS(LINE_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .q_full        (q_full),
        .q_push        (q_push)
    );

    rdtl_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_head  (q_head)
    );

    rdtl_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_byte  (m_token_byte),
        .m_token_class (m_token_class),
        .m_token_end   (m_token_end),
        .m_line_number (m_line_number),
        .m_last_result (m_last_result)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push.valid |-> !q_full)
        else $error("job issued into a full queue");

    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_accept_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !q_full)
        else $error("byte accepted while the queue is full");
`endif

endmodule

/* design/rdtl_front.sv */
// Front end: drops white space, counts lines, holds one character and issues jobs.
module rdtl_front #(
    parameter int LINE_BITS = rdtl_pkg::LINE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_text_byte,
    input  logic                 s_end_of_text,
    input  logic                 q_full,
    output rdtl_pkg::rdtl_push_t q_push
);

    localparam int LOW = rdtl_pkg::LINE_OUT_W;
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

    logic [7:0]           held_byte_reg, held_byte_next;
    logic                 held_valid_reg, held_valid_next;
    logic [LINE_BITS-1:0] held_line_reg, held_line_next;
    logic [LINE_BITS-1:0] line_cnt_reg, line_cnt_next;
    rdtl_pkg::rdtl_entry_t pend_reg, pend_next;
    logic                 pend_valid_reg, pend_valid_next;

    logic acc, lf, vis, e0_valid, flush_valid;
    rdtl_pkg::rdtl_entry_t e0, flush;

    assign s_ready = !pend_valid_reg && !q_full;
    assign acc     = s_valid && s_ready;

    always_comb begin
        lf  = s_text_byte == rdtl_pkg::CH_LF;
        vis = !(s_text_byte == rdtl_pkg::CH_TAB || s_text_byte == rdtl_pkg::CH_SPACE ||
                s_text_byte == rdtl_pkg::CH_CR || lf);

        held_valid_next = held_valid_reg || vis;
        held_byte_next  = vis ? s_text_byte : held_byte_reg;
        held_line_next  = vis ? line_cnt_reg : held_line_reg;
        line_cnt_next   = (lf && line_cnt_reg != LINE_MAX) ? line_cnt_reg + LINE_ONE
                                                           : line_cnt_reg;

        e0_valid   = acc && vis && held_valid_reg;
        e0.tok     = held_byte_reg;
        e0.look    = s_text_byte;
        e0.line    = LOW'(held_line_reg);
        e0.last    = 1'b0;

        // flush against a space on the final byte
        flush_valid = acc && s_end_of_text && held_valid_next;
        flush.tok   = held_byte_next;
        flush.look  = rdtl_pkg::CH_SPACE;
        flush.line  = LOW'(held_line_next);
        flush.last  = 1'b1;

        if (pend_valid_reg) begin
            q_push.valid = !q_full;
            q_push.entry = pend_reg;
        end else if (e0_valid) begin
            q_push.valid = 1'b1;
            q_push.entry = e0;
        end else begin
            q_push.valid = flush_valid;
            q_push.entry = flush;
        end

        pend_next       = flush;
        pend_valid_next = pend_valid_reg ? q_full : (e0_valid && flush_valid);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_byte_reg  <= '0;
            held_line_reg  <= LINE_ONE;
            line_cnt_reg   <= LINE_ONE;
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            if (acc && !pend_valid_reg && e0_valid && flush_valid) begin
                pend_reg <= pend_next;
            end
            if (acc) begin
                if (s_end_of_text) begin
                    held_valid_reg <= 1'b0;
                    held_byte_reg  <= '0;
                    held_line_reg  <= LINE_ONE;
                    line_cnt_reg   <= LINE_ONE;
                end else begin
                    held_valid_reg <= held_valid_next;
                    held_byte_reg  <= held_byte_next;
                    held_line_reg  <= held_line_next;
                    line_cnt_reg   <= line_cnt_next;
                end
            end
        end
    end

endmodule

/* design/rdtl_queue.sv */
// Short job queue between the front end and the classifier.
module rdtl_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rdtl_pkg::rdtl_push_t  q_push,
    output logic                  q_full,
    input  logic                  q_pop,
    output logic                  q_empty,
    output rdtl_pkg::rdtl_entry_t q_head
);

    localparam int PW = rdtl_pkg::Q_PTR_W;
    localparam int CW = rdtl_pkg::Q_PTR_W + 1;

    rdtl_pkg::rdtl_entry_t mem_reg [rdtl_pkg::Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign q_full  = count_reg == CW'(rdtl_pkg::Q_DEPTH);
    assign q_empty = count_reg == '0;
    assign q_head  = mem_reg[rd_ptr_reg];
    assign do_push = q_push.valid && !q_full;
    assign do_pop  = q_pop && !q_empty;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= q_push.entry;
        end
    end

endmodule

/* design/rdtl_back.sv */
// Back end: classifies each job against its lookahead and drives the result register.
module rdtl_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_empty,
    input  rdtl_pkg::rdtl_entry_t q_head,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_token_byte,
    output logic [3:0]            m_token_class,
    output logic                  m_token_end,
    output logic [rdtl_pkg::LINE_OUT_W-1:0] m_line_number,
    output logic                  m_last_result
);

    logic [3:0] lexer_class_reg, lexer_class_next;
    logic       scope_reg, scope_next;
    logic       quote_reg, quote_next;
    logic       m_valid_reg;
    logic [7:0] tok_byte_reg;
    logic [3:0] tok_class_reg;
    logic       tok_end_reg;
    logic [rdtl_pkg::LINE_OUT_W-1:0] line_reg;
    logic       last_reg;

    logic [3:0] cls, pc;
    logic       w, tend;

    assign q_pop = !q_empty && (!m_valid_reg || m_ready);

    always_comb begin
        cls = (lexer_class_reg > rdtl_pkg::CLS_INVALID) ? rdtl_pkg::CLS_INVALID
                                                        : lexer_class_reg;
        w   = rdtl_pkg::is_word(q_head.look);
        pc  = rdtl_pkg::punct_class(q_head.look);
        lexer_class_next = lexer_class_reg;
        scope_next       = scope_reg;
        quote_next       = quote_reg;
        tend             = 1'b0;
        case (cls)
            rdtl_pkg::CLS_REC_HDR, rdtl_pkg::CLS_FLD_HDR: begin
                tend = !w;
            end
            rdtl_pkg::CLS_REC_TYPE, rdtl_pkg::CLS_FLD_NAME: begin
                tend = q_head.look == rdtl_pkg::CH_COMMA;
            end
            rdtl_pkg::CLS_REC_NAME: begin
                tend = quote_reg ? (q_head.look == rdtl_pkg::CH_QUOTE)
                                 : (q_head.look == rdtl_pkg::CH_RPAREN);
            end
            rdtl_pkg::CLS_FLD_VALUE: begin
                tend = quote_reg ? (q_head.look == rdtl_pkg::CH_QUOTE) : !w;
            end
            rdtl_pkg::CLS_LPAREN: begin
                tend = 1'b1;
                lexer_class_next = w ? (scope_reg ? rdtl_pkg::CLS_FLD_NAME
                                                  : rdtl_pkg::CLS_REC_TYPE) : pc;
            end
            rdtl_pkg::CLS_RPAREN: begin
                tend = 1'b1;
                lexer_class_next = w ? (scope_reg ? rdtl_pkg::CLS_FLD_HDR
                                                  : rdtl_pkg::CLS_INVALID) : pc;
            end
            rdtl_pkg::CLS_LBRACE: begin
                tend = 1'b1;
                scope_next = 1'b1;
                lexer_class_next = w ? rdtl_pkg::CLS_FLD_HDR : pc;
            end
            rdtl_pkg::CLS_RBRACE: begin
                tend = 1'b1;
                scope_next = 1'b0;
                lexer_class_next = w ? rdtl_pkg::CLS_REC_HDR : pc;
            end
            rdtl_pkg::CLS_COMMA: begin
                tend = 1'b1;
                lexer_class_next = w ? (scope_reg ? rdtl_pkg::CLS_FLD_VALUE
                                                  : rdtl_pkg::CLS_REC_NAME) : pc;
            end
            rdtl_pkg::CLS_QUOTE: begin
                tend = 1'b1;
                quote_next = !quote_reg;
                // opening quote starts a name or value
                lexer_class_next = !quote_reg ? (scope_reg ? rdtl_pkg::CLS_FLD_VALUE
                                                           : rdtl_pkg::CLS_REC_NAME) : pc;
            end
            default: begin
                if (!scope_reg && !quote_reg && w) begin
                    lexer_class_next = rdtl_pkg::CLS_REC_HDR;
                end
            end
        endcase
        if (tend && cls <= rdtl_pkg::CLS_FLD_VALUE) begin
            lexer_class_next = pc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lexer_class_reg <= rdtl_pkg::CLS_REC_HDR;
            scope_reg       <= 1'b0;
            quote_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (q_pop) begin
                m_valid_reg <= 1'b1;
                // return to the start of a text after its final beat
                if (q_head.last) begin
                    lexer_class_reg <= rdtl_pkg::CLS_REC_HDR;
                    scope_reg       <= 1'b0;
                    quote_reg       <= 1'b0;
                end else begin
                    lexer_class_reg <= lexer_class_next;
                    scope_reg       <= scope_next;
                    quote_reg       <= quote_next;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (q_pop) begin
            tok_byte_reg  <= q_head.tok;
            tok_class_reg <= cls;
            tok_end_reg   <= tend;
            line_reg      <= q_head.line;
            last_reg      <= q_head.last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_token_byte  = tok_byte_reg;
    assign m_token_class = tok_class_reg;
    assign m_token_end   = tok_end_reg;
    assign m_line_number = line_reg;
    assign m_last_result = last_reg;

endmodule

/* tb/sv/tb_record_db_text_lexer_core.sv */
// Self-checking testbench for record_db_text_lexer_core with a token predictor.
module tb_record_db_text_lexer_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 16;
    localparam int          RANDOM_VISIBLE = 360;
    localparam int          QUIET_LO       = 300;
    localparam int          QUIET_HI       = 450;
    localparam int          HOLD_AT        = 150;
    localparam int          HOLD_CYCLES    = 300;
    localparam logic [15:0] LINE_TOP       = 16'hFFFF;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
    } text_beat_t;

    typedef struct {
        logic [7:0]  tok;
        logic [3:0]  cls;
        logic        fin;
        logic [15:0] line;
        logic        last;
    } token_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_text_byte   = 8'h00;
    logic        s_end_of_text = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [7:0]  m_token_byte;
    logic [3:0]  m_token_class;
    logic        m_token_end;
    logic [15:0] m_line_number;
    logic        m_last_result;

    text_beat_t  text_q[$];
    logic [7:0]  stage_q[$];
    token_t      tok_expect[$];
    text_beat_t  beat_nx;
    token_t      tok_exp;

    int n_items   = 0;
    int n_sent    = 0;
    int n_got     = 0;
    int n_fail    = 0;
    int n_vis     = 0;
    int hold_left = 0;
    int idle_cyc  = 0;
    logic mangle  = 1'b0;

    // lexer state as predicted
    logic [3:0]  lx_class     = rdtl_pkg::CLS_REC_HDR;
    logic        lx_scope     = 1'b0;
    logic        lx_quote     = 1'b0;
    logic [7:0]  lx_held      = 8'h00;
    logic        lx_held_ok   = 1'b0;
    logic [15:0] lx_held_line = 16'd1;
    logic [15:0] lx_line      = 16'd1;

    record_db_text_lexer_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_byte  (m_token_byte),
        .m_token_class (m_token_class),
        .m_token_end   (m_token_end),
        .m_line_number (m_line_number),
        .m_last_result (m_last_result)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic word_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == rdtl_pkg::CH_UNDER ||
               c == rdtl_pkg::CH_DOT;
    endfunction

    function automatic logic [3:0] sym_class(input logic [7:0] c);
        case (c)
            rdtl_pkg::CH_LPAREN: return rdtl_pkg::CLS_LPAREN;
            rdtl_pkg::CH_RPAREN: return rdtl_pkg::CLS_RPAREN;
            rdtl_pkg::CH_LBRACE: return rdtl_pkg::CLS_LBRACE;
            rdtl_pkg::CH_RBRACE: return rdtl_pkg::CLS_RBRACE;
            rdtl_pkg::CH_COMMA:  return rdtl_pkg::CLS_COMMA;
            rdtl_pkg::CH_QUOTE:  return rdtl_pkg::CLS_QUOTE;
            default:             return rdtl_pkg::CLS_INVALID;
        endcase
    endfunction

    // Classify the held character against its lookahead and queue the token.
    function automatic void lex_classify(input logic [7:0] c, input logic [7:0] n,
                                         input logic [15:0] ln, input logic last);
        logic [3:0] cls;
        logic       fin;
        logic       w;
        token_t     t;
        cls = (lx_class > rdtl_pkg::CLS_INVALID) ? rdtl_pkg::CLS_INVALID : lx_class;
        fin = 1'b0;
        w   = word_char(n);
        case (cls)
            rdtl_pkg::CLS_REC_HDR, rdtl_pkg::CLS_FLD_HDR: fin = !w;
            rdtl_pkg::CLS_REC_TYPE, rdtl_pkg::CLS_FLD_NAME: fin = (n == rdtl_pkg::CH_COMMA);
            rdtl_pkg::CLS_REC_NAME: begin
                fin = lx_quote ? (n == rdtl_pkg::CH_QUOTE) : (n == rdtl_pkg::CH_RPAREN);
            end
            rdtl_pkg::CLS_FLD_VALUE: fin = lx_quote ? (n == rdtl_pkg::CH_QUOTE) : !w;
            rdtl_pkg::CLS_LPAREN: begin
                fin = 1'b1;
                lx_class = w ? (lx_scope ? rdtl_pkg::CLS_FLD_NAME : rdtl_pkg::CLS_REC_TYPE)
                             : sym_class(n);
            end
            rdtl_pkg::CLS_RPAREN: begin
                fin = 1'b1;
                lx_class = w ? (lx_scope ? rdtl_pkg::CLS_FLD_HDR : rdtl_pkg::CLS_INVALID)
                             : sym_class(n);
            end
            rdtl_pkg::CLS_LBRACE: begin
                fin = 1'b1;
                lx_scope = 1'b1;
                lx_class = w ? rdtl_pkg::CLS_FLD_HDR : sym_class(n);
            end
            rdtl_pkg::CLS_RBRACE: begin
                fin = 1'b1;
                lx_scope = 1'b0;
                lx_class = w ? rdtl_pkg::CLS_REC_HDR : sym_class(n);
            end
            rdtl_pkg::CLS_COMMA: begin
                fin = 1'b1;
                lx_class = w ? (lx_scope ? rdtl_pkg::CLS_FLD_VALUE : rdtl_pkg::CLS_REC_NAME)
                             : sym_class(n);
            end
            rdtl_pkg::CLS_QUOTE: begin
                fin = 1'b1;
                lx_quote = !lx_quote;
                if (lx_quote) begin
                    lx_class = lx_scope ? rdtl_pkg::CLS_FLD_VALUE : rdtl_pkg::CLS_REC_NAME;
                end else begin
                    lx_class = sym_class(n);
                end
            end
            default: begin
                // an invalid run ends once a word starts at top level
                if (!lx_scope && !lx_quote && w) lx_class = rdtl_pkg::CLS_REC_HDR;
            end
        endcase
        if (fin && cls <= rdtl_pkg::CLS_FLD_VALUE) lx_class = sym_class(n);
        t.tok  = c;
        t.cls  = cls;
        t.fin  = fin;
        t.line = ln;
        t.last = last;
        tok_expect.push_back(t);
    endfunction

    function automatic void lex_accept(input logic [7:0] b, input logic eot);
        if (b == rdtl_pkg::CH_LF) begin
            if (lx_line != LINE_TOP) lx_line = lx_line + 16'd1;
        end else if (b != rdtl_pkg::CH_TAB && b != rdtl_pkg::CH_SPACE &&
                     b != rdtl_pkg::CH_CR) begin
            if (lx_held_ok) lex_classify(lx_held, b, lx_held_line, 1'b0);
            lx_held      = b;
            lx_held_line = lx_line;
            lx_held_ok   = 1'b1;
        end
        if (eot) begin
            // flush against a space, then start a fresh text
            if (lx_held_ok) lex_classify(lx_held, rdtl_pkg::CH_SPACE, lx_held_line, 1'b1);
            lx_class     = rdtl_pkg::CLS_REC_HDR;
            lx_scope     = 1'b0;
            lx_quote     = 1'b0;
            lx_held      = 8'h00;
            lx_held_ok   = 1'b0;
            lx_held_line = 16'd1;
            lx_line      = 16'd1;
        end
    endfunction

    // Text building
    function automatic void put(input logic [7:0] c);
        stage_q.push_back(c);
        if (c != rdtl_pkg::CH_TAB && c != rdtl_pkg::CH_SPACE &&
            c != rdtl_pkg::CH_CR && c != rdtl_pkg::CH_LF) n_vis++;
    endfunction

    function automatic void put_str(input string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endfunction

    function automatic void end_text();
        text_beat_t bt;
        while (stage_q.size() > 0) begin
            bt.ch  = stage_q.pop_front();
            bt.eot = (stage_q.size() == 0);
            text_q.push_back(bt);
        end
    endfunction

    function automatic logic [7:0] word_pick();
        int r;
        r = $urandom_range(0, 63);
        if (r < 26) return 8'h61 + 8'(r);
        if (r < 52) return 8'h41 + 8'(r - 26);
        if (r < 62) return 8'h30 + 8'(r - 52);
        return (r == 62) ? rdtl_pkg::CH_UNDER : rdtl_pkg::CH_DOT;
    endfunction

    function automatic void put_word();
        repeat ($urandom_range(1, 5)) put(word_pick());
    endfunction

    function automatic void put_ws();
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
                0: put(rdtl_pkg::CH_SPACE);
                1: put(rdtl_pkg::CH_TAB);
                2: put(rdtl_pkg::CH_CR);
                default: put(rdtl_pkg::CH_LF);
            endcase
        end
    endfunction

    // In a broken record, drop or garble some punctuation
    function automatic void put_sym(input logic [7:0] c);
        if (mangle && $urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 1) == 1) put(8'($urandom_range(0, 255)));
        end else begin
            put(c);
        end
    endfunction

    function automatic void put_value();
        if ($urandom_range(0, 1) == 1) begin
            put_sym(rdtl_pkg::CH_QUOTE);
            put_word();
            put_ws();
            put_word();
            put_sym(rdtl_pkg::CH_QUOTE);
        end else begin
            put_word();
        end
    endfunction

    function automatic void put_record();
        put_ws();
        put_word();
        put_ws();
        put_sym(rdtl_pkg::CH_LPAREN);
        put_word();
        put_sym(rdtl_pkg::CH_COMMA);
        put_ws();
        put_value();
        put_sym(rdtl_pkg::CH_RPAREN);
        put_ws();
        if ($urandom_range(0, 3) != 0) begin
            put_sym(rdtl_pkg::CH_LBRACE);
            repeat ($urandom_range(0, 3)) begin
                put_ws();
                put_word();
                put_sym(rdtl_pkg::CH_LPAREN);
                put_word();
                put_sym(rdtl_pkg::CH_COMMA);
                put_ws();
                put_value();
                put_sym(rdtl_pkg::CH_RPAREN);
            end
            put_ws();
            put_sym(rdtl_pkg::CH_RBRACE);
        end
        put_ws();
    endfunction

    // Sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid       <= 1'b0;
            s_text_byte   <= 8'h00;
            s_end_of_text <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                lex_accept(s_text_byte, s_end_of_text);
                n_sent++;
            end
            if (!s_valid || s_ready) begin
                if (text_q.size() > 0 &&
                    !((n_sent < QUIET_LO || n_sent >= QUIET_HI) &&
                      $urandom_range(0, 99) < 25)) begin
                    beat_nx = text_q.pop_front();
                    s_valid       <= 1'b1;
                    s_text_byte   <= beat_nx.ch;
                    s_end_of_text <= beat_nx.eot;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_got++;
                if (tok_expect.size() == 0) begin
                    $error("unexpected token beat: byte %0h class %0d",
                           m_token_byte, m_token_class);
                    n_fail++;
                end else begin
                    tok_exp = tok_expect.pop_front();
                    if (m_token_byte !== tok_exp.tok) begin
                        $error("token_byte: expected %0h, got %0h", tok_exp.tok, m_token_byte);
                        n_fail++;
                    end
                    if (m_token_class !== tok_exp.cls) begin
                        $error("token_class: expected %0d, got %0d",
                               tok_exp.cls, m_token_class);
                        n_fail++;
                    end
                    if (m_token_end !== tok_exp.fin) begin
                        $error("token_end: expected %0b, got %0b", tok_exp.fin, m_token_end);
                        n_fail++;
                    end
                    if (m_line_number !== tok_exp.line) begin
                        $error("line_number: expected %0d, got %0d",
                               tok_exp.line, m_line_number);
                        n_fail++;
                    end
                    if (m_last_result !== tok_exp.last) begin
                        $error("last_result: expected %0b, got %0b",
                               tok_exp.last, m_last_result);
                        n_fail++;
                    end
                end
                // hold off once for a long stretch so the block backs up
                if (n_got == HOLD_AT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !((n_sent < QUIET_LO || n_sent >= QUIET_HI) &&
                             $urandom_range(0, 99) < 25);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cyc = 0;
        end else begin
            idle_cyc++;
            if (idle_cyc >= WATCHDOG_LIMIT) begin
                $display("record_db_text_lexer_core test failed");
                $finish;
            end
        end
    end

    initial begin
        // bracketed record, dropped bytes, blank lines, last byte visible
        put_str("a");
        put(rdtl_pkg::CH_TAB);
        put_str("(b,c)");
        put(rdtl_pkg::CH_CR);
        put(rdtl_pkg::CH_LF);
        put(rdtl_pkg::CH_LF);
        put_str("{d(e,");
        put(rdtl_pkg::CH_QUOTE);
        put_str("f");
        put(rdtl_pkg::CH_QUOTE);
        put_str(")}");
        end_text();
        // text with nothing visible
        put(rdtl_pkg::CH_LF);
        end_text();
        // invalid bytes, recovery to record header, stray close paren
        put_str("x");
        put(8'hFF);
        put_str("y)z");
        put(8'h00);
        end_text();

        n_vis = 0;
        while (n_vis < RANDOM_VISIBLE) begin
            case ($urandom_range(0, 9))
                8, 9: begin
                    repeat ($urandom_range(1, 12)) put(8'($urandom_range(0, 255)));
                end
                default: begin
                    mangle = ($urandom_range(0, 7) == 0);
                    repeat ($urandom_range(1, 3)) put_record();
                    mangle = 1'b0;
                end
            endcase
            end_text();
        end

        n_items = text_q.size();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        wait (n_sent == n_items);
        while (tok_expect.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (n_fail == 0) begin
            $display("record_db_text_lexer_core test passed");
        end else begin
            $display("record_db_text_lexer_core test failed");
        end
        $finish;
    end

endmodule

/* record_db_text_lexer_core.f */
design/rdtl_pkg.sv
design/rdtl_front.sv
design/rdtl_queue.sv
design/rdtl_back.sv
design/record_db_text_lexer_core.sv
tb/sv/tb_record_db_text_lexer_core.sv
